/* design/dmsp_pkg.sv */
// Shared types, codes and constants of the delta-modulation sample player.
package dmsp_pkg;

  // Word kinds carried on the input tuser
  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_ENABLE    = 3'd1,
    MODE_IRQ_CLEAR = 3'd2,
    MODE_FETCH     = 3'd3,
    MODE_LEVEL     = 3'd4
  } mode_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_RATE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOOP  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_IRQ   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_START = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COUNT = 3'd4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] ADDR_LAST = 16'hFFFF;
  localparam logic [15:0] ADDR_WRAP = 16'h8000;
  localparam logic [15:0] START_RST = 16'hC000;
  localparam logic [11:0] COUNT_RST = 12'd1;
  localparam logic [6:0]  LEVEL_TOP = 7'd125;
  localparam logic [6:0]  LEVEL_LOW = 7'd2;
  localparam logic [3:0]  BITS_FULL = 4'd7;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  typedef struct packed {
    logic [3:0]  rate_index;
    logic        loop_enable;
    logic        irq_enable;
    logic [15:0] start_address;
    logic [11:0] sample_byte_count;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [CfgIdxW-1:0]   index;
    logic [CfgDataW-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    mode_e      mode;
    logic       enable_value;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        bytes_active;
    logic [15:0] fetch_address;
    logic        fetch_request;
    logic        irq_line;
    logic [6:0]  level;
  } result_t;

  // Divider period for each rate index
  function automatic logic [8:0] rate_period(input logic [3:0] idx);
    logic [8:0] p;
    case (idx)
      4'd0:    p = 9'd428;
      4'd1:    p = 9'd380;
      4'd2:    p = 9'd340;
      4'd3:    p = 9'd320;
      4'd4:    p = 9'd286;
      4'd5:    p = 9'd254;
      4'd6:    p = 9'd226;
      4'd7:    p = 9'd214;
      4'd8:    p = 9'd190;
      4'd9:    p = 9'd160;
      4'd10:   p = 9'd142;
      4'd11:   p = 9'd128;
      4'd12:   p = 9'd106;
      4'd13:   p = 9'd84;
      4'd14:   p = 9'd72;
      default: p = 9'd54;
    endcase
    return p;
  endfunction

  // Move the level by two in the direction of the bit, clamped at the rails
  function automatic logic [6:0] level_step(input logic [6:0] lvl, input logic bit_v);
    logic [6:0] r;
    r = lvl;
    if (bit_v && lvl <= LEVEL_TOP) begin
      r = lvl + 7'd2;
    end else if (!bit_v && lvl >= LEVEL_LOW) begin
      r = lvl - 7'd2;
    end
    return r;
  endfunction

endpackage

/* design/dmsp_cfg.sv */
// Configuration register file of the delta-modulation sample player.
module dmsp_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dmsp_pkg::cfg_wr_t wr_i,
  output dmsp_pkg::cfg_t   cfg_o
);

  dmsp_pkg::cfg_t cfg_q;

  // Latch a register on a write to its index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_index        <= 4'd0;
      cfg_q.loop_enable       <= 1'b0;
      cfg_q.irq_enable        <= 1'b0;
      cfg_q.start_address     <= dmsp_pkg::START_RST;
      cfg_q.sample_byte_count <= dmsp_pkg::COUNT_RST;
    end else if (wr_i.we) begin
      unique case (wr_i.index)
        dmsp_pkg::CFG_RATE:  cfg_q.rate_index        <= wr_i.data[3:0];
        dmsp_pkg::CFG_LOOP:  cfg_q.loop_enable       <= wr_i.data[0];
        dmsp_pkg::CFG_IRQ:   cfg_q.irq_enable        <= wr_i.data[0];
        dmsp_pkg::CFG_START: cfg_q.start_address     <= wr_i.data[15:0];
        dmsp_pkg::CFG_COUNT: cfg_q.sample_byte_count <= wr_i.data[11:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/dmsp_core.sv */
// Channel state and its update for one input word.
module dmsp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  dmsp_pkg::item_t   item_i,
  input  dmsp_pkg::cfg_t    cfg_i,
  input  dmsp_pkg::cfg_wr_t wr_i,
  output dmsp_pkg::result_t result_o
);

  logic [6:0]  level_q, level_d;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  bits_q, bits_d;
  logic        silenced_q, silenced_d;
  logic [15:0] raddr_q, raddr_d;
  logic [11:0] bytes_q, bytes_d;
  logic [8:0]  div_q, div_d;
  logic        enabled_q, enabled_d;
  logic        irq_q, irq_d;
  logic        await_q, await_d;

  // Next state for a config write or an accepted word
  always_comb begin
    level_d    = level_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    silenced_d = silenced_q;
    raddr_d    = raddr_q;
    bytes_d    = bytes_q;
    div_d      = div_q;
    enabled_d  = enabled_q;
    irq_d      = irq_q;
    await_d    = await_q;

    if (wr_i.we) begin
      // rate write reloads the divider; irq disable drops the pending flag
      if (wr_i.index == dmsp_pkg::CFG_RATE) begin
        div_d = dmsp_pkg::rate_period(wr_i.data[3:0]);
      end
      if (wr_i.index == dmsp_pkg::CFG_IRQ && !wr_i.data[0]) begin
        irq_d = 1'b0;
      end
    end else if (fire_i) begin
      case (item_i.mode)
        dmsp_pkg::MODE_TICK: begin
          if (enabled_q && !await_q) begin
            if (div_q == 9'd0) begin
              div_d = dmsp_pkg::rate_period(cfg_i.rate_index);
              if (bits_q != 4'd0) begin
                // shift one bit out and apply it
                bits_d  = bits_q - 4'd1;
                shift_d = {1'b0, shift_q[7:1]};
                if (!silenced_q) begin
                  level_d = dmsp_pkg::level_step(level_q, shift_q[0]);
                end
              end else if (bytes_q == 12'd0 && !cfg_i.loop_enable) begin
                // sample over: go silent, drain one bit
                if (cfg_i.irq_enable) begin
                  irq_d = 1'b1;
                end
                silenced_d = 1'b1;
                bits_d     = dmsp_pkg::BITS_FULL;
                shift_d    = {1'b0, shift_q[7:1]};
              end else if (bytes_q == 12'd0) begin
                // loop: restart and request the first byte
                raddr_d = cfg_i.start_address;
                bytes_d = (cfg_i.sample_byte_count != 12'd0)
                          ? cfg_i.sample_byte_count - 12'd1 : 12'd0;
                await_d = 1'b1;
              end else begin
                bytes_d = bytes_q - 12'd1;
                await_d = 1'b1;
              end
            end else begin
              div_d = div_q - 9'd1;
            end
          end
        end
        dmsp_pkg::MODE_ENABLE: begin
          enabled_d = item_i.enable_value;
          if (!item_i.enable_value) begin
            bytes_d = 12'd0;
          end else if (bytes_q == 12'd0) begin
            raddr_d = cfg_i.start_address;
            bytes_d = cfg_i.sample_byte_count;
          end
        end
        dmsp_pkg::MODE_IRQ_CLEAR: irq_d = 1'b0;
        dmsp_pkg::MODE_FETCH: begin
          if (await_q) begin
            // load the fetched byte and apply its first bit
            await_d    = 1'b0;
            shift_d    = {1'b0, item_i.data_byte[7:1]};
            raddr_d    = (raddr_q == dmsp_pkg::ADDR_LAST) ? dmsp_pkg::ADDR_WRAP
                                                          : raddr_q + 16'd1;
            silenced_d = 1'b0;
            bits_d     = dmsp_pkg::BITS_FULL;
            level_d    = dmsp_pkg::level_step(level_q, item_i.data_byte[0]);
          end
        end
        dmsp_pkg::MODE_LEVEL: level_d = item_i.data_byte[6:0];
        default: ;
      endcase
    end
  end

  // Hold channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= 7'd0;
      shift_q    <= 8'd0;
      bits_q     <= 4'd0;
      silenced_q <= 1'b1;
      raddr_q    <= 16'd0;
      bytes_q    <= 12'd0;
      div_q      <= 9'd0;
      enabled_q  <= 1'b0;
      irq_q      <= 1'b0;
      await_q    <= 1'b0;
    end else begin
      level_q    <= level_d;
      shift_q    <= shift_d;
      bits_q     <= bits_d;
      silenced_q <= silenced_d;
      raddr_q    <= raddr_d;
      bytes_q    <= bytes_d;
      div_q      <= div_d;
      enabled_q  <= enabled_d;
      irq_q      <= irq_d;
      await_q    <= await_d;
    end
  end

  // Result reflects the state after this word
  assign result_o.level         = level_d;
  assign result_o.irq_line      = irq_d;
  assign result_o.fetch_request = await_d;
  assign result_o.fetch_address = await_d ? raddr_d : 16'd0;
  assign result_o.bytes_active  = (bytes_d != 12'd0);

endmodule

/* design/delta_modulation_sample_player_unit.sv */
// Top level of the delta-modulation sample player: stream ports, input and result registers.
// Each input word (tick, enable write, interrupt clear, fetch reply or level load) yields
// exactly one result word with the level, interrupt line, pending fetch request and address,
// and a bytes-active flag. One word is taken every clock cycle while the result side is not
// stalling; a word's result passes through an input register, the state update and a result
// register. A fetch request is answered by sending a fetch-reply word with the
// byte; ticks are ignored until then. Configuration writes are taken at once, one per cycle,
// and are meant to be issued while no word is in flight.
module delta_modulation_sample_player_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [0] enable_value, [8:1] data_byte, [15:9] zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] mode
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [6:0] level, [7] irq_line, [8] fetch_request,
                                     // [24:9] fetch_address, [25] bytes_active, [31:26] zero
);

  dmsp_pkg::cfg_t    cfg;
  dmsp_pkg::cfg_wr_t wr;
  dmsp_pkg::item_t   item_q;
  dmsp_pkg::result_t result;
  dmsp_pkg::result_t out_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic              fire;

  assign wr.we    = cfg_we_i;
  assign wr.index = cfg_index_i;
  assign wr.data  = cfg_data_i;

  // Pipeline moves when the result register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Capture an input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.mode         <= dmsp_pkg::mode_e'(s_axis_tuser);
      item_q.enable_value <= s_axis_tdata[0];
      item_q.data_byte    <= s_axis_tdata[8:1];
    end
  end

  dmsp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .cfg_o  (cfg)
  );

  dmsp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .wr_i     (wr),
    .result_o (result)
  );

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule

/* verif/delta_modulation_sample_player_unit_test.sv */
// Self-checking stream testbench for the delta-modulation sample player unit.
module delta_modulation_sample_player_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned LongHold    = 40;
  localparam logic [2:0]  ModeLast    = 3'd7;
  localparam logic [2:0]  CfgIdxLast  = 3'd7;

  // One result word, laid out as on m_axis_tdata
  typedef struct packed {
    logic [5:0]  pad;
    logic        active;
    logic [15:0] addr;
    logic        fetch;
    logic        irq;
    logic [6:0]  level;
  } report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  delta_modulation_sample_player_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Channel image kept by the testbench
  logic [3:0]  cfg_rate;
  logic        cfg_loop;
  logic        cfg_irq_en;
  logic [15:0] cfg_start;
  logic [11:0] cfg_count;
  logic [6:0]  lvl;
  logic [7:0]  shifter;
  logic [3:0]  bit_count;
  logic        muted;
  logic [15:0] fetch_ptr;
  logic [11:0] bytes_remaining;
  logic [8:0]  divider;
  logic        running;
  logic        irq_pending;
  logic        fetch_pending;

  report_t     channel_reports[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned hold_request;
  bit          sender_gaps;
  bit          receiver_gaps;

  // Divider reload value per rate index
  function automatic logic [8:0] divider_period(input logic [3:0] idx);
    logic [8:0] p;
    case (idx)
      4'd0:  p = 9'd428;
      4'd1:  p = 9'd380;
      4'd2:  p = 9'd340;
      4'd3:  p = 9'd320;
      4'd4:  p = 9'd286;
      4'd5:  p = 9'd254;
      4'd6:  p = 9'd226;
      4'd7:  p = 9'd214;
      4'd8:  p = 9'd190;
      4'd9:  p = 9'd160;
      4'd10: p = 9'd142;
      4'd11: p = 9'd128;
      4'd12: p = 9'd106;
      4'd13: p = 9'd84;
      4'd14: p = 9'd72;
      default: p = 9'd54;
    endcase
    return p;
  endfunction

  function automatic void reset_channel();
    cfg_rate        = 4'd0;
    cfg_loop        = 1'b0;
    cfg_irq_en      = 1'b0;
    cfg_start       = dmsp_pkg::START_RST;
    cfg_count       = dmsp_pkg::COUNT_RST;
    lvl             = 7'd0;
    shifter         = 8'd0;
    bit_count       = 4'd0;
    muted           = 1'b1;
    fetch_ptr       = 16'd0;
    bytes_remaining = 12'd0;
    divider         = 9'd0;
    running         = 1'b0;
    irq_pending     = 1'b0;
    fetch_pending   = 1'b0;
  endfunction

  // Drop one bit off the shifter; move the level unless silenced
  function automatic void shift_bit();
    logic b;
    b = shifter[0];
    shifter = shifter >> 1;
    if (!muted) begin
      if (b && lvl <= dmsp_pkg::LEVEL_TOP) begin
        lvl = lvl + 7'd2;
      end else if (!b && lvl >= dmsp_pkg::LEVEL_LOW) begin
        lvl = lvl - 7'd2;
      end
    end
  endfunction

  // Divider ran out: use a bit, request a byte, or end the sample
  function automatic void expire_divider();
    if (bit_count != 0) begin
      bit_count = bit_count - 4'd1;
      shift_bit();
    end else if (bytes_remaining == 0 && !cfg_loop) begin
      if (cfg_irq_en) begin
        irq_pending = 1'b1;
      end
      muted = 1'b1;
      bit_count = dmsp_pkg::BITS_FULL;
      shift_bit();
    end else begin
      if (bytes_remaining == 0) begin
        fetch_ptr = cfg_start;
        bytes_remaining = cfg_count;
      end
      if (bytes_remaining != 0) begin
        bytes_remaining = bytes_remaining - 12'd1;
      end
      fetch_pending = 1'b1;
    end
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] value);
    case (idx)
      dmsp_pkg::CFG_RATE: begin
        cfg_rate = value[3:0];
        divider = divider_period(value[3:0]);
      end
      dmsp_pkg::CFG_LOOP:  cfg_loop = value[0];
      dmsp_pkg::CFG_IRQ: begin
        cfg_irq_en = value[0];
        if (!value[0]) begin
          irq_pending = 1'b0;
        end
      end
      dmsp_pkg::CFG_START: cfg_start = value;
      dmsp_pkg::CFG_COUNT: cfg_count = value[11:0];
      default: ;
    endcase
  endfunction

  // Advance the channel image by one accepted word and queue its report
  function automatic void step_channel(input logic [2:0] mode, input logic en,
                                       input logic [7:0] data);
    report_t r;
    case (mode)
      dmsp_pkg::MODE_TICK: begin
        if (running && !fetch_pending) begin
          if (divider == 0) begin
            divider = divider_period(cfg_rate);
            expire_divider();
          end else begin
            divider = divider - 9'd1;
          end
        end
      end
      dmsp_pkg::MODE_ENABLE: begin
        running = en;
        if (!en) begin
          bytes_remaining = 12'd0;
        end else if (bytes_remaining == 0) begin
          fetch_ptr = cfg_start;
          bytes_remaining = cfg_count;
        end
      end
      dmsp_pkg::MODE_IRQ_CLEAR: irq_pending = 1'b0;
      dmsp_pkg::MODE_FETCH: begin
        if (fetch_pending) begin
          fetch_pending = 1'b0;
          shifter = data;
          fetch_ptr = (fetch_ptr == dmsp_pkg::ADDR_LAST) ? dmsp_pkg::ADDR_WRAP
                                                         : fetch_ptr + 16'd1;
          muted = 1'b0;
          bit_count = dmsp_pkg::BITS_FULL;
          shift_bit();
        end
      end
      dmsp_pkg::MODE_LEVEL: lvl = data[6:0];
      default: ;
    endcase
    r.pad    = 6'd0;
    r.active = (bytes_remaining != 0);
    r.addr   = fetch_pending ? fetch_ptr : 16'd0;
    r.fetch  = fetch_pending;
    r.irq    = irq_pending;
    r.level  = lvl;
    channel_reports.push_back(r);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < ReportLimit) begin
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
      mismatches++;
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Compare each result word with the oldest queued report
  always @(posedge clk_i) begin : check_reports
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (channel_reports.size() == 0) begin
        if (mismatches < ReportLimit) begin
          $display("result word %h with no report waiting", m_axis_tdata);
        end
        mismatches++;
      end else begin
        want = channel_reports.pop_front();
        check_field("level", want.level, m_axis_tdata[6:0]);
        check_field("irq_line", want.irq, m_axis_tdata[7]);
        check_field("fetch_request", want.fetch, m_axis_tdata[8]);
        check_field("fetch_address", want.addr, m_axis_tdata[24:9]);
        check_field("bytes_active", want.active, m_axis_tdata[25]);
        check_field("padding", want.pad, m_axis_tdata[31:26]);
      end
    end
  end

  // Drive the result-side ready: long holds on request, short random stalls
  initial begin : drive_ready
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Offer one word, hold it until taken, then predict its report
  task automatic send_word(input logic [2:0] mode, input logic en, input logic [7:0] data);
    @(negedge clk_i);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {7'd0, data, en};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    step_channel(mode, en, data);
  endtask

  // Pause the input until every queued report has come back
  task automatic wait_reports_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (channel_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    apply_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Pick a word that keeps playback moving; answer pending fetches mostly
  task automatic send_random_word(output bit counted);
    logic [2:0]  mode;
    logic        en;
    logic [7:0]  data;
    int unsigned pick;
    en   = 1'($urandom_range(0, 1));
    data = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (fetch_pending && $urandom_range(0, 1) == 0) begin
      mode = dmsp_pkg::MODE_FETCH;
    end else if (!running && pick < 50) begin
      mode = dmsp_pkg::MODE_ENABLE;
      en = 1'b1;
    end else if (pick < 84) begin
      mode = dmsp_pkg::MODE_TICK;
    end else if (pick < 88) begin
      mode = dmsp_pkg::MODE_ENABLE;
      en = ($urandom_range(0, 3) != 0);
    end else if (pick < 90) begin
      mode = dmsp_pkg::MODE_IRQ_CLEAR;
    end else if (pick < 94) begin
      mode = dmsp_pkg::MODE_LEVEL;
      // favor levels at and next to the rails
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 3))
          0: data = 8'h00;
          1: data = 8'h01;
          2: data = 8'h7E;
          default: data = 8'hFF;
        endcase
      end
    end else if (pick < 97) begin
      mode = dmsp_pkg::MODE_FETCH;
    end else begin
      mode = 3'($urandom_range(dmsp_pkg::MODE_LEVEL + 1, ModeLast));
    end
    case (mode) inside
      dmsp_pkg::MODE_TICK:  counted = running && !fetch_pending;
      dmsp_pkg::MODE_FETCH: counted = fetch_pending;
      dmsp_pkg::MODE_ENABLE, dmsp_pkg::MODE_IRQ_CLEAR, dmsp_pkg::MODE_LEVEL: counted = 1'b1;
      default: counted = 1'b0;
    endcase
    send_word(mode, en, data);
  endtask

  // Settle, program every register (junk in unused bits), then play at random
  task automatic run_episode(input logic [3:0] rate, input logic loop_en, input logic irq_en,
                             input logic [15:0] start, input logic [11:0] count,
                             input int unsigned words, input bit gaps);
    logic [15:0] junk;
    int unsigned done;
    bit          counted;
    wait_reports_drained();
    junk = 16'($urandom());
    write_reg(dmsp_pkg::CFG_RATE, {junk[15:4], rate});
    write_reg(dmsp_pkg::CFG_LOOP, {junk[15:1], loop_en});
    write_reg(dmsp_pkg::CFG_IRQ, {junk[14:0], irq_en});
    write_reg(dmsp_pkg::CFG_START, start);
    write_reg(dmsp_pkg::CFG_COUNT, {junk[3:0], count});
    sender_gaps = gaps;
    receiver_gaps = gaps;
    done = 0;
    while (done < words) begin
      send_random_word(counted);
      if (counted) begin
        done++;
      end
    end
  endtask

  // Reset-time behavior, ignored words, first fetch, rail hold and address wrap
  task automatic test_directed();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    write_reg(dmsp_pkg::CFG_START, dmsp_pkg::ADDR_LAST);
    write_reg(dmsp_pkg::CFG_COUNT, 16'hF002);
    write_reg(dmsp_pkg::CFG_LOOP, 16'h0001);
    write_reg(dmsp_pkg::CFG_IRQ, 16'h0001);
    for (int i = dmsp_pkg::CFG_COUNT + 1; i <= CfgIdxLast; i++) begin
      write_reg(i[2:0], 16'hFFFF);
    end
    send_word(dmsp_pkg::MODE_TICK, 1'b1, 8'hFF);
    for (int m = dmsp_pkg::MODE_LEVEL + 1; m <= ModeLast; m++) begin
      send_word(m[2:0], 1'b1, 8'hFF);
    end
    send_word(dmsp_pkg::MODE_IRQ_CLEAR, 1'b0, 8'h00);
    send_word(dmsp_pkg::MODE_LEVEL, 1'b0, 8'hFE);
    send_word(dmsp_pkg::MODE_ENABLE, 1'b0, 8'h00);
    send_word(dmsp_pkg::MODE_ENABLE, 1'b1, 8'h00);
    // reply with nothing pending
    send_word(dmsp_pkg::MODE_FETCH, 1'b0, 8'hAA);
    // divider starts at zero: the first tick requests the top address
    send_word(dmsp_pkg::MODE_TICK, 1'b0, 8'h00);
    send_word(dmsp_pkg::MODE_TICK, 1'b0, 8'h00);
    // disabling leaves the fetch pending
    send_word(dmsp_pkg::MODE_ENABLE, 1'b0, 8'h00);
    // up step at 126 holds; address wraps to the bottom of the window
    send_word(dmsp_pkg::MODE_FETCH, 1'b0, 8'h01);
    send_word(dmsp_pkg::MODE_LEVEL, 1'b1, 8'h7F);
    send_word(dmsp_pkg::MODE_LEVEL, 1'b0, 8'h00);
    send_word(dmsp_pkg::MODE_LEVEL, 1'b1, 8'h01);
    send_word(dmsp_pkg::MODE_ENABLE, 1'b1, 8'hFF);
    send_word(dmsp_pkg::MODE_TICK, 1'b1, 8'h00);
  endtask

  // Slowest and fastest rates, address and count rails
  task automatic test_config_extremes();
    run_episode(4'd0, 1'b0, 1'b0, 16'h0000, 12'd4095, 100, 1'b1);
    run_episode(4'd15, 1'b1, 1'b1, dmsp_pkg::ADDR_LAST, 12'd0, 450, 1'b1);
  endtask

  // Run out of bytes without looping: silence and interrupt
  task automatic test_sample_end();
    run_episode(4'd15, 1'b0, 1'b1, 16'hFFFE, 12'd0, 400, 1'b0);
  endtask

  // Hold the result side long enough to stall input, then pause the sender
  task automatic test_backpressure();
    bit counted;
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    send_word(dmsp_pkg::MODE_ENABLE, 1'b1, 8'($urandom_range(0, 255)));
    hold_request = LongHold;
    repeat (60) begin
      send_word(dmsp_pkg::MODE_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
    wait_reports_drained();
    receiver_gaps = 1'b1;
    repeat (20) send_random_word(counted);
  endtask

  // Random settings, mostly fast rates and short samples
  task automatic test_random_play();
    logic [3:0]  rate;
    logic [11:0] count;
    logic [15:0] start;
    for (int e = 0; e < 3; e++) begin
      rate = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0) begin
        rate = 4'($urandom_range(12, 15));
      end
      case ($urandom_range(0, 5))
        0: count = 12'd0;
        1, 2: count = 12'd1;
        3: count = 12'd2;
        4: count = 12'd3;
        default: count = 12'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 3))
        0: start = dmsp_pkg::ADDR_LAST;
        1: start = 16'hFFFE;
        2: start = 16'h0000;
        default: start = 16'($urandom_range(0, 65535));
      endcase
      // first pass clears the interrupt enable and any pending interrupt
      run_episode(rate, 1'($urandom_range(0, 1)), (e == 0) ? 1'b0 : 1'($urandom_range(0, 1)),
                  start, count, 200, e != 1);
    end
  endtask

  // Close with no idling on either side
  task automatic test_calm_finish();
    run_episode(4'd15, 1'b1, 1'b1, 16'hFFFE, 12'd1, 150, 1'b0);
  endtask

  initial begin : run_tests
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = dmsp_pkg::CFG_RATE;
    cfg_data_i    = 16'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    s_axis_tuser  = dmsp_pkg::MODE_TICK;
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    hold_request  = 0;
    mismatches    = 0;
    cycle_count   = 0;
    reset_channel();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_config_extremes();
    test_sample_end();
    test_backpressure();
    test_random_play();
    test_calm_finish();

    wait_reports_drained();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
